/* hw/rtl/prt_pkg.sv */
// Shared types, constants and helpers of the page frame residency table.
// Used by prt_engine and the top level; depends on nothing else.
package prt_pkg;

    localparam int NUM_FRAMES = 64;
    localparam int SLOT_W     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CNT_W      = $clog2(NUM_FRAMES + 1);
    localparam int PAGE_W     = 32;
    localparam int PIN_W      = 16;

    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 72;

    localparam logic [2:0] REQ_LOOKUP   = 3'd0;
    localparam logic [2:0] REQ_LOAD     = 3'd1;
    localparam logic [2:0] REQ_ALLOC_AT = 3'd2;
    localparam logic [2:0] REQ_CREATE   = 3'd3;
    localparam logic [2:0] REQ_UNPIN    = 3'd4;

    localparam logic [2:0] STAT_OK             = 3'd0;
    localparam logic [2:0] STAT_NOT_FOUND      = 3'd1;
    localparam logic [2:0] STAT_OUT_OF_SPACE   = 3'd2;
    localparam logic [2:0] STAT_ALREADY_EXISTS = 3'd3;
    localparam logic [2:0] STAT_BACKING_FAILED = 3'd4;

    typedef struct packed {
        logic              dirty;
        logic [PIN_W-1:0]  pins;
        logic [PAGE_W-1:0] page;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        logic [2:0]        req_type;
        logic [PAGE_W-1:0] page_id;
        logic              keep_pin;
        logic              backing_ok;
        logic [5:0]        unpin_slot;
    } t_request;

    typedef struct packed {
        logic [2:0]        status;
        logic [5:0]        frame_slot;
        logic [PAGE_W-1:0] result_page_id;
        logic              frame_dirty;
        logic [PIN_W-1:0]  frame_pins;
        logic [6:0]        free_frames;
        logic [6:0]        used_frames;
    } t_result;

    function automatic logic [5:0] slot_field(input logic [SLOT_W-1:0] slot);
        logic [31:0] wide;
        wide = 32'(slot);
        return wide[5:0];
    endfunction

    function automatic logic [6:0] count_field(input logic [CNT_W-1:0] cnt);
        logic [31:0] wide;
        wide = 32'(cnt);
        return wide[6:0];
    endfunction

endpackage

/* hw/rtl/prt_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; the entry store of the residency table is built from it.
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/prt_engine.sv */
// Request sequencer of the residency table: scan, read-modify-write and result register.
// Depends on prt_pkg and drives the ports of one prt_ram holding the frame entries.
module prt_engine
    import prt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_request          i_req,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output logic              o_ram_wr_en,
    output logic [SLOT_W-1:0] o_ram_wr_addr,
    output t_entry            o_ram_wr_data,
    output logic              o_ram_rd_en,
    output logic [SLOT_W-1:0] o_ram_rd_addr,
    input  t_entry            i_ram_rd_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UNPIN,
        ST_EXEC,
        ST_DONE
    } t_state;

    t_state                r_state;
    logic [2:0]            r_req;
    logic [PAGE_W-1:0]     r_page;
    logic                  r_keep;
    logic                  r_ok;
    logic                  r_hit;
    logic [SLOT_W-1:0]     r_slot;
    t_entry                r_ent;
    logic [CNT_W-1:0]      r_scan;
    logic [SLOT_W-1:0]     r_cmp_addr;
    logic                  r_rd_pend;
    logic [CNT_W-1:0]      r_free;
    logic [NUM_FRAMES-1:0] r_valid;
    t_result               r_res;
    t_result               r_out;
    logic                  r_out_valid;

    logic                  accept;
    logic [31:0]           us_ext;
    logic                  us_in_range;
    logic [SLOT_W-1:0]     us_idx;
    logic                  unpin_hit;
    logic                  need_scan;
    logic                  scan_match;
    logic                  scan_issue;
    logic                  scan_miss;
    logic                  out_load;

    logic [PIN_W-1:0]      pin_inc;
    logic [PIN_W-1:0]      pin_dec;
    logic [SLOT_W-1:0]     alloc_slot;
    logic                  alloc_req;
    logic                  alloc_dirty;
    logic [PIN_W-1:0]      alloc_pins;
    logic                  ex_wr;
    logic [SLOT_W-1:0]     ex_addr;
    t_entry                ex_data;
    logic                  ex_alloc;
    logic                  ex_clr;
    logic                  ex_report;
    logic [2:0]            ex_status;
    logic [CNT_W-1:0]      free_after;
    t_result               ex_res;
    logic [NUM_FRAMES-1:0] n_valid;

    assign accept      = i_req_valid && o_req_ready;
    assign us_ext      = 32'(i_req.unpin_slot);
    assign us_in_range = us_ext < 32'(NUM_FRAMES);
    assign us_idx      = us_ext[SLOT_W-1:0];
    assign unpin_hit   = us_in_range && r_valid[us_idx];
    assign need_scan   = (i_req.req_type == REQ_LOOKUP) || (i_req.req_type == REQ_LOAD)
                      || (i_req.req_type == REQ_ALLOC_AT)
                      || ((i_req.req_type == REQ_CREATE) && (r_free != '0)
                          && i_req.backing_ok);

    assign scan_match = (r_state == ST_SCAN) && r_rd_pend && r_valid[r_cmp_addr]
                     && (i_ram_rd_data.page == r_page);
    assign scan_issue = (r_state == ST_SCAN) && (r_scan != CNT_W'(NUM_FRAMES)) && !scan_match;
    assign scan_miss  = (r_state == ST_SCAN) && r_rd_pend && !scan_match
                     && (r_scan == CNT_W'(NUM_FRAMES));
    assign out_load   = (r_state == ST_DONE) && (!r_out_valid || i_res_ready);

    assign o_ram_rd_en   = scan_issue || (accept && (i_req.req_type == REQ_UNPIN) && unpin_hit);
    assign o_ram_rd_addr = (r_state == ST_SCAN) ? r_scan[SLOT_W-1:0] : us_idx;

    always_comb begin
        pin_inc     = (r_ent.pins == '1) ? r_ent.pins : r_ent.pins + PIN_W'(1);
        pin_dec     = (r_ent.pins == '0) ? r_ent.pins : r_ent.pins - PIN_W'(1);
        alloc_slot  = SLOT_W'(r_free - CNT_W'(1));
        alloc_req   = 1'b0;
        alloc_dirty = 1'b0;
        alloc_pins  = '0;
        ex_wr       = 1'b0;
        ex_addr     = r_slot;
        ex_data     = r_ent;
        ex_alloc    = 1'b0;
        ex_clr      = 1'b0;
        ex_report   = 1'b0;
        ex_status   = STAT_NOT_FOUND;

        unique case (r_req)
            REQ_LOOKUP: begin
                if (r_hit) begin
                    ex_wr        = 1'b1;
                    ex_data.pins = pin_inc;
                    ex_report    = 1'b1;
                    ex_status    = STAT_OK;
                end
            end
            REQ_LOAD: begin
                if (r_hit) begin
                    ex_wr        = 1'b1;
                    ex_data.pins = r_keep ? pin_inc : r_ent.pins;
                    ex_report    = 1'b1;
                    ex_status    = STAT_OK;
                end else begin
                    alloc_req   = 1'b1;
                    alloc_dirty = 1'b0;
                    alloc_pins  = PIN_W'(r_keep);
                end
            end
            REQ_ALLOC_AT: begin
                if (r_hit) begin
                    ex_report = 1'b1;
                    ex_status = STAT_ALREADY_EXISTS;
                end else begin
                    alloc_req   = 1'b1;
                    alloc_dirty = 1'b1;
                    alloc_pins  = PIN_W'(r_keep);
                end
            end
            REQ_CREATE: begin
                ex_clr      = r_hit;
                alloc_req   = 1'b1;
                alloc_dirty = 1'b1;
                alloc_pins  = '0;
            end
            REQ_UNPIN: begin
                if (r_hit) begin
                    ex_wr        = 1'b1;
                    ex_data.pins = pin_dec;
                    ex_report    = 1'b1;
                    ex_status    = STAT_OK;
                end
            end
            default: begin
            end
        endcase

        if (alloc_req) begin
            if (r_free == '0) begin
                ex_status = STAT_OUT_OF_SPACE;
            end else if (!r_ok) begin
                ex_status = STAT_BACKING_FAILED;
            end else begin
                ex_alloc      = 1'b1;
                ex_wr         = 1'b1;
                ex_addr       = alloc_slot;
                ex_data.dirty = alloc_dirty;
                ex_data.pins  = alloc_pins;
                ex_data.page  = r_page;
                ex_report     = 1'b1;
                ex_status     = STAT_OK;
            end
        end

        free_after               = r_free - CNT_W'(ex_alloc);
        ex_res.status            = ex_status;
        ex_res.frame_slot        = ex_report ? slot_field(ex_addr) : '0;
        ex_res.result_page_id    = ex_report ? ex_data.page : '0;
        ex_res.frame_dirty       = ex_report ? ex_data.dirty : 1'b0;
        ex_res.frame_pins        = ex_report ? ex_data.pins : '0;
        ex_res.free_frames       = count_field(free_after);
        ex_res.used_frames       = count_field(CNT_W'(NUM_FRAMES) - free_after);

        n_valid = r_valid;
        if (ex_clr) begin
            n_valid[r_slot] = 1'b0;
        end
        if (ex_alloc) begin
            n_valid[alloc_slot] = 1'b1;
        end
    end

    assign o_ram_wr_en   = (r_state == ST_EXEC) && ex_wr;
    assign o_ram_wr_addr = ex_addr;
    assign o_ram_wr_data = ex_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_valid     <= '0;
            r_free      <= CNT_W'(NUM_FRAMES);
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_pend <= scan_issue;
            if (scan_issue) begin
                r_cmp_addr <= r_scan[SLOT_W-1:0];
                r_scan     <= r_scan + CNT_W'(1);
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_res_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_req  <= i_req.req_type;
                        r_page <= i_req.page_id;
                        r_keep <= i_req.keep_pin;
                        r_ok   <= i_req.backing_ok;
                        r_hit  <= 1'b0;
                        r_slot <= us_idx;
                        if (i_req.req_type == REQ_UNPIN) begin
                            r_state <= unpin_hit ? ST_UNPIN : ST_EXEC;
                        end else if (need_scan && (r_free != CNT_W'(NUM_FRAMES))) begin
                            r_scan  <= r_free;
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_EXEC;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_match) begin
                        r_hit   <= 1'b1;
                        r_slot  <= r_cmp_addr;
                        r_ent   <= i_ram_rd_data;
                        r_state <= ST_EXEC;
                    end else if (scan_miss) begin
                        r_state <= ST_EXEC;
                    end
                end
                ST_UNPIN: begin
                    r_hit   <= 1'b1;
                    r_ent   <= i_ram_rd_data;
                    r_state <= ST_EXEC;
                end
                ST_EXEC: begin
                    r_res   <= ex_res;
                    r_free  <= free_after;
                    r_valid <= n_valid;
                    r_state <= ST_DONE;
                end
                ST_DONE: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_free) <= NUM_FRAMES)
        else $error("free count above the number of frames");

    a_mapped_within_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) <= (NUM_FRAMES - 32'(r_free)))
        else $error("more mapped frames than used frames");

    a_alloc_pops_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC) && ex_alloc |=> r_free == $past(r_free) - CNT_W'(1))
        else $error("allocation did not take exactly one free slot");

    a_hit_in_used_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_match |-> CNT_W'(r_cmp_addr) >= r_free)
        else $error("scan hit on a slot that is still free");

endmodule

/* hw/rtl/page_frame_residency_table.sv */
// Top level of the page frame residency table: stream ports, request and result packing.
// Depends on prt_pkg, prt_engine and prt_ram.
//
// A request that must find a page id (lookup, lookup-or-load, alloc-at, and create-new when a
// frame can be taken) reads the used frames from the entry memory one per cycle, stopping early
// on a hit; unpin of a mapped slot reads only its own entry. The single read port of the entry
// memory sets this scan rate. One request is worked on at a time, and a new request is taken
// while the previous result still waits in the output register.
module page_frame_residency_table
    import prt_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // page_id[31:0], keep_pin[32], backing_ok[33], unpin_slot[39:34]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[2:0]
    input  logic [2:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // frame_slot[5:0], result_page_id[37:6], frame_dirty[38], frame_pins[54:39],
    // free_frames[61:55], used_frames[68:62], zero[71:69]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]             o_m_axis_tuser
);

    t_request          req;
    t_result           res;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    t_entry            ram_wr_data;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    t_entry            ram_rd_data;

    always_comb begin
        req.req_type   = i_s_axis_tuser;
        req.page_id    = i_s_axis_tdata[31:0];
        req.keep_pin   = i_s_axis_tdata[32];
        req.backing_ok = i_s_axis_tdata[33];
        req.unpin_slot = i_s_axis_tdata[39:34];
    end

    assign o_m_axis_tdata = {3'b000, res.used_frames, res.free_frames, res.frame_pins,
                             res.frame_dirty, res.result_page_id, res.frame_slot};
    assign o_m_axis_tuser = res.status;

    prt_engine u_engine (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_s_axis_tvalid),
        .o_req_ready   (o_s_axis_tready),
        .i_req         (req),
        .o_res_valid   (o_m_axis_tvalid),
        .i_res_ready   (i_m_axis_tready),
        .o_res         (res),
        .o_ram_wr_en   (ram_wr_en),
        .o_ram_wr_addr (ram_wr_addr),
        .o_ram_wr_data (ram_wr_data),
        .o_ram_rd_en   (ram_rd_en),
        .o_ram_rd_addr (ram_rd_addr),
        .i_ram_rd_data (ram_rd_data)
    );

    prt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_FRAMES)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

endmodule
